// ----- rtl/bra_pkg.sv -----
// Shared constants, codes and types of the bitmap run allocator.
package bra_pkg;

    localparam int MAP_BYTES = 128;
    localparam int BYTE_W = 8;
    localparam int ADDR_W = $clog2(MAP_BYTES);
    localparam int ECNT_W = $clog2(MAP_BYTES + 1);
    localparam int NBITS_W = ECNT_W + 3;
    localparam int CFG_W = 8;
    localparam int MODE_W = 3;
    localparam int IDX_W = 10;
    localparam int LEN_W = 11;
    localparam int STATUS_W = 2;

    localparam logic [CFG_W-1:0] CFG_RESET = CFG_W'(MAP_BYTES);

    localparam logic [MODE_W-1:0] MODE_SCAN = 3'd0;
    localparam logic [MODE_W-1:0] MODE_SET = 3'd1;
    localparam logic [MODE_W-1:0] MODE_CLEAR = 3'd2;
    localparam logic [MODE_W-1:0] MODE_TEST = 3'd3;
    localparam logic [MODE_W-1:0] MODE_CLEAR_ALL = 3'd4;

    localparam logic [STATUS_W-1:0] ST_OK = 2'd0;
    localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd1;
    localparam logic [STATUS_W-1:0] ST_RANGE = 2'd2;

    // Request from the sequencer to the bitmap store; the store reads addr every cycle.
    typedef struct packed {
        logic              we;
        logic              clr_all;
        logic [ADDR_W-1:0] addr;
        logic [BYTE_W-1:0] wdata;
    } bra_req_t;

    // Result of the run unit over one byte.
    typedef struct packed {
        logic             hit;
        logic [2:0]       hit_pos;
        logic [LEN_W-1:0] run_out;
    } bra_run_t;

endpackage

// ----- rtl/bra_store.sv -----
// Bitmap store: byte memory with per-byte valid bits, registered read.
module bra_store (
    input  logic                  clk,
    input  logic                  rst_n,
    input  bra_pkg::bra_req_t     req,
    output logic [bra_pkg::BYTE_W-1:0] rd_byte
);
    import bra_pkg::*;

    logic [BYTE_W-1:0]    mem [MAP_BYTES];
    logic [MAP_BYTES-1:0] valid_reg;
    logic [BYTE_W-1:0]    rd_data_reg;
    logic                 rd_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            rd_valid_reg <= valid_reg[req.addr];
            if (req.clr_all)
            begin
                valid_reg <= '0;
            end
            else if (req.we)
            begin
                valid_reg[req.addr] <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        rd_data_reg <= mem[req.addr];
        if (req.we)
        begin
            mem[req.addr] <= req.wdata;
        end
    end

    // A byte never written since the last clear reads as free
    assign rd_byte = rd_valid_reg ? rd_data_reg : '0;

endmodule

// ----- rtl/bra_run_unit.sv -----
// Run unit: extends the free-bit run count across one bitmap byte.
module bra_run_unit (
    input  logic [bra_pkg::BYTE_W-1:0] byte_data,
    input  logic [bra_pkg::LEN_W-1:0]  run_in,
    input  logic [bra_pkg::LEN_W-1:0]  run_len,
    output bra_pkg::bra_run_t          res
);
    import bra_pkg::*;

    always_comb
    begin
        logic [LEN_W-1:0] run;
        logic             hit;
        logic [2:0]       pos;
        run = run_in;
        hit = 1'b0;
        pos = '0;
        for (int b = 0; b < BYTE_W; b++)
        begin
            if (!hit)
            begin
                if (byte_data[b])
                begin
                    run = '0;
                end
                else
                begin
                    run = run + LEN_W'(1);
                    if (run == run_len)
                    begin
                        hit = 1'b1;
                        pos = 3'(b);
                    end
                end
            end
        end
        res.hit = hit;
        res.hit_pos = pos;
        res.run_out = run;
    end

endmodule

// ----- rtl/bra_ctrl.sv -----
// Sequencer: decodes a transaction, drives the store and run unit, holds the result.
module bra_ctrl (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [bra_pkg::MODE_W-1:0]    mode,
    input  logic [bra_pkg::IDX_W-1:0]     bit_index,
    input  logic [bra_pkg::LEN_W-1:0]     run_length,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [bra_pkg::STATUS_W-1:0]  status,
    output logic [bra_pkg::IDX_W-1:0]     start_index,
    output logic                          bit_value,
    input  logic [bra_pkg::ECNT_W-1:0]    map_bytes,
    output bra_pkg::bra_req_t             req,
    input  logic [bra_pkg::BYTE_W-1:0]    rd_byte
);
    import bra_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE   = 4'b0001,
        S_BIT    = 4'b0010,
        S_SCAN   = 4'b0100,
        S_FINISH = 4'b1000
    } state_t;

    state_t               state_reg, state_next;
    logic [MODE_W-1:0]    mode_reg, mode_next;
    logic [2:0]           bit_off_reg, bit_off_next;
    logic [ADDR_W-1:0]    addr_reg, addr_next;
    logic [ADDR_W-1:0]    last_reg, last_next;
    logic [LEN_W-1:0]     len_reg, len_next;
    logic [LEN_W-1:0]     run_reg, run_next;
    logic [STATUS_W-1:0]  res_status_reg, res_status_next;
    logic [IDX_W-1:0]     res_start_reg, res_start_next;
    logic                 res_value_reg, res_value_next;
    logic                 out_valid_reg, out_valid_next;
    logic [STATUS_W-1:0]  out_status_reg;
    logic [IDX_W-1:0]     out_start_reg;
    logic                 out_value_reg;
    logic                 out_load;

    logic [NBITS_W-1:0]   nbits;
    logic [BYTE_W-1:0]    bit_mask;
    logic [LEN_W-1:0]     hit_end;
    bra_run_t             run_res;

    bra_run_unit u_run (
        .byte_data (rd_byte),
        .run_in    (run_reg),
        .run_len   (len_reg),
        .res       (run_res)
    );

    assign nbits = {map_bytes, 3'b000};
    assign bit_mask = BYTE_W'(1) << bit_off_reg;
    assign hit_end = LEN_W'({addr_reg, run_res.hit_pos}) + LEN_W'(1);

    assign in_ready = (state_reg == S_IDLE);
    assign out_load = (state_reg == S_FINISH) && (!out_valid_reg || out_ready);

    always_comb
    begin
        state_next = state_reg;
        mode_next = mode_reg;
        bit_off_next = bit_off_reg;
        addr_next = addr_reg;
        last_next = last_reg;
        len_next = len_reg;
        run_next = run_reg;
        res_status_next = res_status_reg;
        res_start_next = res_start_reg;
        res_value_next = res_value_reg;
        req.we = 1'b0;
        req.clr_all = 1'b0;
        req.addr = addr_reg;
        req.wdata = '0;

        case (state_reg)
            S_IDLE:
            begin
                req.addr = '0;
                if (in_valid)
                begin
                    mode_next = mode;
                    res_status_next = ST_OK;
                    res_start_next = '0;
                    res_value_next = 1'b0;
                    state_next = S_FINISH;
                    case (mode)
                        MODE_SCAN:
                        begin
                            if (run_length == '0 || NBITS_W'(run_length) > nbits
                                || run_length > LEN_W'(nbits))
                            begin
                                res_status_next = ST_NOT_FOUND;
                            end
                            else
                            begin
                                addr_next = '0;
                                run_next = '0;
                                len_next = run_length;
                                last_next = ADDR_W'(map_bytes - ECNT_W'(1));
                                state_next = S_SCAN;
                            end
                        end
                        MODE_SET, MODE_CLEAR, MODE_TEST:
                        begin
                            req.addr = ADDR_W'(bit_index >> 3);
                            if (NBITS_W'(bit_index) >= nbits)
                            begin
                                res_status_next = ST_RANGE;
                            end
                            else
                            begin
                                addr_next = ADDR_W'(bit_index >> 3);
                                bit_off_next = bit_index[2:0];
                                state_next = S_BIT;
                            end
                        end
                        MODE_CLEAR_ALL:
                        begin
                            req.clr_all = 1'b1;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            S_BIT:
            begin
                case (mode_reg)
                    MODE_SET:
                    begin
                        req.we = 1'b1;
                        req.wdata = rd_byte | bit_mask;
                    end
                    MODE_CLEAR:
                    begin
                        req.we = 1'b1;
                        req.wdata = rd_byte & ~bit_mask;
                    end
                    default:
                    begin
                        res_value_next = rd_byte[bit_off_reg];
                    end
                endcase
                state_next = S_FINISH;
            end
            S_SCAN:
            begin
                // Prefetch the next byte while this one is evaluated
                req.addr = addr_reg + ADDR_W'(1);
                if (run_res.hit)
                begin
                    res_status_next = ST_OK;
                    res_start_next = IDX_W'(hit_end - len_reg);
                    state_next = S_FINISH;
                end
                else if (addr_reg == last_reg)
                begin
                    res_status_next = ST_NOT_FOUND;
                    state_next = S_FINISH;
                end
                else
                begin
                    run_next = run_res.run_out;
                    addr_next = addr_reg + ADDR_W'(1);
                end
            end
            S_FINISH:
            begin
                if (out_load)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mode_reg <= mode_next;
        bit_off_reg <= bit_off_next;
        addr_reg <= addr_next;
        last_reg <= last_next;
        len_reg <= len_next;
        run_reg <= run_next;
        res_status_reg <= res_status_next;
        res_start_reg <= res_start_next;
        res_value_reg <= res_value_next;
        if (out_load)
        begin
            out_status_reg <= res_status_reg;
            out_start_reg <= res_start_reg;
            out_value_reg <= res_value_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign status = out_status_reg;
    assign start_index = out_start_reg;
    assign bit_value = out_value_reg;

endmodule

// ----- rtl/bitmap_run_allocator.sv -----
// Top level of the first-fit bitmap run allocator.
//
//   channel   signals                                   direction
//   in        in_valid/in_ready, mode, bit_index,       request into block
//             run_length
//   out       out_valid/out_ready, status,              result out of block
//             start_index, bit_value
//   cfg       cfg_valid/cfg_ready, cfg_data             bytes_in_use write
//
// Set, clear and test read their byte, then act on it in S_BIT; clear all,
// unused modes and rejected requests go from S_IDLE straight to S_FINISH. A scan
// reads bytes until a run ends (at most bytes_in_use, held to 128), taking
// one byte a cycle through the single-port store and the shared run unit.
// Reset clears the map at once through per-byte valid bits; no clearing pass.
// The block takes a new request only after the last result is in the output
// register; a stalled output holds one result while the next request runs.
module bitmap_run_allocator (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [bra_pkg::MODE_W-1:0]    mode,
    input  logic [bra_pkg::IDX_W-1:0]     bit_index,
    input  logic [bra_pkg::LEN_W-1:0]     run_length,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [bra_pkg::STATUS_W-1:0]  status,
    output logic [bra_pkg::IDX_W-1:0]     start_index,
    output logic                          bit_value,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [bra_pkg::CFG_W-1:0]     cfg_data
);
    import bra_pkg::*;

    logic [CFG_W-1:0]  bytes_in_use_reg;
    logic [ECNT_W-1:0] map_bytes;
    bra_req_t          req;
    logic [BYTE_W-1:0] rd_byte;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bytes_in_use_reg <= CFG_RESET;
        end
        else if (cfg_valid)
        begin
            bytes_in_use_reg <= cfg_data;
        end
    end

    // Saturate the byte count to the store depth
    assign map_bytes = (int'(bytes_in_use_reg) > MAP_BYTES) ? ECNT_W'(MAP_BYTES)
                                                            : ECNT_W'(bytes_in_use_reg);

    bra_store u_store (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (req),
        .rd_byte (rd_byte)
    );

    bra_ctrl u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .mode        (mode),
        .bit_index   (bit_index),
        .run_length  (run_length),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .status      (status),
        .start_index (start_index),
        .bit_value   (bit_value),
        .map_bytes   (map_bytes),
        .req         (req),
        .rd_byte     (rd_byte)
    );

endmodule

// ----- rtl/bra_checker.sv -----
// Port-level checker for the bitmap run allocator, bound to the top level.
module bra_checker (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    input  logic                          in_ready,
    input  logic                          out_valid,
    input  logic                          out_ready,
    input  logic [bra_pkg::STATUS_W-1:0]  status,
    input  logic [bra_pkg::IDX_W-1:0]     start_index,
    input  logic                          bit_value
);
    import bra_pkg::*;

    // Hold a stalled result
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(status)
            && $stable(start_index) && $stable(bit_value))
        else $error("stalled result changed");

    // Drop ready for at least the cycle after a transaction
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("request accepted back to back");

    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> status == ST_OK || status == ST_NOT_FOUND || status == ST_RANGE)
        else $error("undefined status code");

    a_start_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status != ST_OK |-> start_index == '0)
        else $error("start index set on failed request");

    a_value_ok: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && bit_value |-> status == ST_OK && start_index == '0)
        else $error("bit value set on non-test result");

endmodule

bind bitmap_run_allocator bra_checker u_bra_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .status      (status),
    .start_index (start_index),
    .bit_value   (bit_value)
);

// ----- tb/sv/tb.sv -----
// Self-checking testbench for the first-fit bitmap run allocator.
`timescale 1ns / 100ps

module tb;
    import bra_pkg::*;

    localparam int CYCLE_LIMIT = 1_500_000;
    localparam int SCAN_SETTLE = 2 * MAP_BYTES + 16;
    localparam int HOLD_CYCLES = 400;
    localparam int PHASES = 6;

    typedef struct {
        logic [STATUS_W-1:0] status;
        logic [IDX_W-1:0]    start;
        logic                value;
    } alloc_outcome_t;

    // Tracks the allocation map and the results it should produce, in order.
    class alloc_tracker;
        logic [MAP_BYTES*BYTE_W-1:0] used_bits;
        logic [CFG_W-1:0]            bytes_in_use;
        alloc_outcome_t              awaited_results[$];
        int                          fails;

        function new();
            used_bits = '0;
            bytes_in_use = CFG_RESET;
            fails = 0;
        endfunction

        function void set_bytes(logic [CFG_W-1:0] value);
            bytes_in_use = value;
        endfunction

        function int unsigned active_bits();
            int unsigned e;
            e = (int'(bytes_in_use) > MAP_BYTES) ? MAP_BYTES : int'(bytes_in_use);
            return e * BYTE_W;
        endfunction

        function int outstanding();
            return awaited_results.size();
        endfunction

        function void note_request(logic [MODE_W-1:0] m, logic [IDX_W-1:0] idx,
                                   logic [LEN_W-1:0] len);
            alloc_outcome_t r;
            int unsigned    nb;
            int unsigned    run;
            r.status = ST_OK;
            r.start = '0;
            r.value = 1'b0;
            nb = active_bits();
            case (m)
                MODE_SCAN:
                begin
                    r.status = ST_NOT_FOUND;
                    if (len != 0 && len <= nb)
                    begin
                        run = 0;
                        for (int unsigned i = 0; i < nb; i++)
                        begin
                            if (used_bits[i])
                                run = 0;
                            else
                            begin
                                run++;
                                if (run == len)
                                begin
                                    r.start = IDX_W'(i + 1 - len);
                                    r.status = ST_OK;
                                    break;
                                end
                            end
                        end
                    end
                end
                MODE_SET, MODE_CLEAR, MODE_TEST:
                begin
                    if (idx >= nb)
                        r.status = ST_RANGE;
                    else if (m == MODE_SET)
                        used_bits[idx] = 1'b1;
                    else if (m == MODE_CLEAR)
                        used_bits[idx] = 1'b0;
                    else
                        r.value = used_bits[idx];
                end
                MODE_CLEAR_ALL:
                    used_bits = '0;
                default:
                    ;
            endcase
            awaited_results.push_back(r);
        endfunction

        function void report_field(string field, int unsigned want, int unsigned got);
            $display("%0t: %s mismatch: expected %0d, actual %0d", $time, field, want, got);
            fails++;
        endfunction

        function void check_result(logic [STATUS_W-1:0] got_status,
                                   logic [IDX_W-1:0] got_start, logic got_value);
            alloc_outcome_t want;
            if (awaited_results.size() == 0)
            begin
                $display("%0t: unexpected result: expected none, actual status %0d %s",
                         $time, got_status,
                         $sformatf("start %0d bit %0d", got_start, got_value));
                fails++;
                return;
            end
            want = awaited_results.pop_front();
            if (got_status !== want.status)
                report_field("status", want.status, got_status);
            if (got_start !== want.start)
                report_field("start_index", want.start, got_start);
            if (got_value !== want.value)
                report_field("bit_value", want.value, got_value);
        endfunction
    endclass

    logic                clk;
    logic                rst_n = 1'b0;
    logic                in_valid = 1'b0;
    logic                in_ready;
    logic [MODE_W-1:0]   mode = MODE_SCAN;
    logic [IDX_W-1:0]    bit_index = '0;
    logic [LEN_W-1:0]    run_length = '0;
    logic                out_valid;
    logic                out_ready = 1'b0;
    logic [STATUS_W-1:0] status;
    logic [IDX_W-1:0]    start_index;
    logic                bit_value;
    logic                cfg_valid = 1'b0;
    logic                cfg_ready;
    logic [CFG_W-1:0]    cfg_data = '0;

    alloc_tracker tracker = new();
    int send_idle_pct = 22;
    int recv_idle_pct = 72;
    int hold_pending = 0;
    int hold_done = 0;
    int cycle_count = 0;

    bitmap_run_allocator i_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .mode        (mode),
        .bit_index   (bit_index),
        .run_length  (run_length),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .status      (status),
        .start_index (start_index),
        .bit_value   (bit_value),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_data    (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("tb failed");
            $finish;
        end
    end

    // Result side: random back-pressure, plus one long hold-off on request.
    initial
    begin
        forever
        begin
            @(posedge clk);
            if (hold_pending != hold_done)
            begin
                out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_done = hold_pending;
            end
            else
                out_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
            tracker.check_result(status, start_index, bit_value);
    end

    task automatic send_item(logic [MODE_W-1:0] m, logic [IDX_W-1:0] idx,
                             logic [LEN_W-1:0] len);
        if ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
        end
        in_valid <= 1'b1;
        mode <= m;
        bit_index <= idx;
        run_length <= len;
        do @(posedge clk); while (!in_ready);
        tracker.note_request(m, idx, len);
    endtask

    task automatic send_random();
        int unsigned       nb;
        int unsigned       pick;
        int unsigned       sel;
        int unsigned       win;
        logic [MODE_W-1:0] m;
        logic [IDX_W-1:0]  idx;
        logic [LEN_W-1:0]  len;
        nb = tracker.active_bits();
        idx = IDX_W'($urandom_range(1023));
        len = LEN_W'($urandom_range(2047));
        pick = $urandom_range(99);
        if (pick < 30)
            m = MODE_SET;
        else if (pick < 45)
            m = MODE_CLEAR;
        else if (pick < 60)
            m = MODE_TEST;
        else if (pick < 90)
            m = MODE_SCAN;
        else if (pick < 92)
            m = MODE_CLEAR_ALL;
        else if (pick < 95)
            m = MODE_W'($urandom_range(5, 7));
        else
            m = MODE_W'($urandom_range(1, 3));
        // Keep most bit writes low in the map so scans meet fragmented runs.
        if (pick < 60 && nb != 0)
        begin
            win = (nb > 64 && $urandom_range(1) == 1) ? 64 : nb;
            idx = IDX_W'($urandom_range(win - 1));
        end
        if (m == MODE_SCAN)
        begin
            sel = $urandom_range(19);
            if (sel < 10)
                len = LEN_W'($urandom_range(1, 8));
            else if (sel < 15)
                len = LEN_W'($urandom_range(1, 64));
            else if (sel < 17)
                len = LEN_W'($urandom_range(1, (nb == 0) ? 1 : nb));
            else if (sel == 17)
                len = '0;
            else if (sel == 18)
                len = LEN_W'($urandom_range(nb + 1, 2047));
            else
                len = LEN_W'($urandom_range(2047));
        end
        send_item(m, idx, len);
    endtask

    task automatic wait_idle(int settle);
        in_valid <= 1'b0;
        while (tracker.outstanding() != 0)
            @(posedge clk);
        repeat (settle) @(posedge clk);
    endtask

    task automatic write_map_size(logic [CFG_W-1:0] value);
        wait_idle(2);
        cfg_valid <= 1'b1;
        cfg_data <= value;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        tracker.set_bytes(value);
    endtask

    initial
    begin
        logic [CFG_W-1:0] phase_bytes[PHASES];
        int               phase_items[PHASES];
        phase_bytes = '{8'd128, 8'd1, 8'd0, 8'd255, 8'd16, 8'd2};
        phase_items = '{300, 100, 60, 300, 200, 240};
        phase_bytes[5] = CFG_W'($urandom_range(2, 127));

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: empty map, both ends of the map, odd modes, clear all.
        send_item(MODE_SCAN, 10'd0, 11'd0);
        send_item(MODE_SCAN, 10'd0, 11'd1);
        send_item(MODE_SCAN, 10'd0, 11'd1024);
        send_item(MODE_SCAN, 10'd1023, 11'd2047);
        send_item(MODE_SET, 10'd0, 11'd0);
        send_item(MODE_SET, 10'd1023, 11'd2047);
        send_item(MODE_TEST, 10'd1023, 11'd0);
        send_item(MODE_TEST, 10'd0, 11'd0);
        send_item(MODE_SCAN, 10'd0, 11'd1);
        send_item(MODE_SCAN, 10'd0, 11'd1022);
        send_item(MODE_SCAN, 10'd0, 11'd1023);
        send_item(MODE_CLEAR, 10'd0, 11'd0);
        send_item(MODE_SCAN, 10'd0, 11'd1023);
        send_item(MODE_SET, 10'd5, 11'd0);
        send_item(MODE_SCAN, 10'd0, 11'd8);
        send_item(3'd5, 10'd1023, 11'd2047);
        send_item(3'd6, 10'd512, 11'd1024);
        send_item(3'd7, 10'd0, 11'd0);
        send_item(MODE_TEST, 10'd512, 11'd0);
        send_item(MODE_CLEAR_ALL, 10'd1023, 11'd2047);
        send_item(MODE_TEST, 10'd1023, 11'd0);
        send_item(MODE_SCAN, 10'd0, 11'd1024);

        for (int p = 0; p < PHASES; p++)
        begin
            write_map_size(phase_bytes[p]);
            if (p < 2)
            begin
                send_idle_pct = 22;
                recv_idle_pct = 72;
            end
            else if (p < 4)
            begin
                send_idle_pct = 72;
                recv_idle_pct = 22;
            end
            else
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            // Stall the result side while requests keep coming.
            if (p == 3)
                hold_pending++;
            for (int n = 0; n < phase_items[p]; n++)
                send_random();
        end

        wait_idle(SCAN_SETTLE);
        if (tracker.fails == 0)
            $display("tb passed");
        else
            $display("tb failed");
        $finish;
    end

endmodule
